FILE: sv/assert_macros.svh
// assertion macros used by the top level of the record engine
// no dependencies; taken in by `include

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define LCAR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define LCAR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lcar_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the learned clause activity reducer
// no dependencies; every other .sv file refers to it by scoped names

package lcar_pkg;

   // table geometry
   localparam int ENTRIES        = 1024;
   localparam int INDEX_W        = $clog2(ENTRIES);
   localparam int COUNT_W        = INDEX_W + 1;
   localparam int REDUCE_MINIMUM = 200;

   // field widths
   localparam int MODE_W   = 3;
   localparam int LIT_W    = 16;
   localparam int ACT_W    = 48;
   localparam int FACTOR_W = 17;
   localparam int FRAC_W   = 16;
   localparam int MARK_W   = 9;
   localparam int CFG_N_W  = 11;

   // decay multiplier split into two partial products
   localparam int HALF_W = ACT_W / 2;
   localparam int PROD_W = HALF_W + FACTOR_W;
   localparam int SUM_W  = ACT_W + FACTOR_W;

   // fixed point constants, Q32.16 activity and Q1.16 factor
   localparam logic [ACT_W-1:0]    ONE_Q16     = 48'h0000_0001_0000;
   localparam logic [ACT_W-1:0]    TWO_Q16     = 48'h0000_0002_0000;
   localparam logic [ACT_W-1:0]    ACT_MAX     = '1;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 17'h1_0000;
   localparam logic [FACTOR_W-1:0] DECAY_RESET = 17'd62259;
   localparam logic [LIT_W-1:0]    LIT_KEEP    = 16'd2;

   // floor(x/3) as (x*683)>>11, exact for x below 2048
   localparam int THIRD_RECIP  = 683;
   localparam int THIRD_W      = 10;
   localparam int THIRD_SHIFT  = 11;
   localparam int THIRD_PROD_W = COUNT_W + THIRD_W;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CSR_ENTRIES_IN_USE = 1'b0,
      CSR_DECAY_FACTOR   = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 3'd0,
      MODE_BUMP   = 3'd1,
      MODE_DECAY  = 3'd2,
      MODE_REDUCE = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SINGLE_RD,
      ST_SINGLE_WB,
      ST_DECAY,
      ST_COUNT,
      ST_BUDGET,
      ST_MARK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              learned;
      logic              removed;
      logic [LIT_W-1:0]  literal_count;
      logic [ACT_W-1:0]  activity;
   } record_type;

   typedef struct packed {
      logic               rd_en;
      logic [INDEX_W-1:0] rd_addr;
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
      record_type         wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [CFG_N_W-1:0]  entries_in_use;
      logic [FACTOR_W-1:0] decay_factor;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
      logic               learned_in;
      logic               removed_in;
      logic [LIT_W-1:0]   literal_count;
      logic [ACT_W-1:0]   activity_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index_out;
      logic               learned_out;
      logic               removed_out;
      logic [ACT_W-1:0]   activity_out;
      logic [COUNT_W-1:0] live_learned;
      logic [MARK_W-1:0]  removed_now;
      logic               reduce_ran;
   } rsp_type;

endpackage

FILE: sv/lcar_req_if.sv
`timescale 1ns / 1ps
// request channel of the learned clause activity reducer
// depends on lcar_pkg for field widths

interface lcar_req_if;
   logic                         valid;
   logic                         ready;
   logic [lcar_pkg::MODE_W-1:0]  mode;
   logic [lcar_pkg::INDEX_W-1:0] index;
   logic                         learned_in;
   logic                         removed_in;
   logic [lcar_pkg::LIT_W-1:0]   literal_count;
   logic [lcar_pkg::ACT_W-1:0]   activity_in;

   modport source (
      output valid, mode, index, learned_in, removed_in, literal_count, activity_in,
      input  ready
   );

   modport sink (
      input  valid, mode, index, learned_in, removed_in, literal_count, activity_in,
      output ready
   );
endinterface

FILE: sv/lcar_rsp_if.sv
`timescale 1ns / 1ps
// response channel of the learned clause activity reducer
// depends on lcar_pkg for field widths

interface lcar_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcar_pkg::INDEX_W-1:0] index_out;
   logic                         learned_out;
   logic                         removed_out;
   logic [lcar_pkg::ACT_W-1:0]   activity_out;
   logic [lcar_pkg::COUNT_W-1:0] live_learned;
   logic [lcar_pkg::MARK_W-1:0]  removed_now;
   logic                         reduce_ran;

   modport source (
      output valid, index_out, learned_out, removed_out, activity_out,
             live_learned, removed_now, reduce_ran,
      input  ready
   );

   modport sink (
      input  valid, index_out, learned_out, removed_out, activity_out,
             live_learned, removed_now, reduce_ran,
      output ready
   );
endinterface

FILE: sv/learned_clause_activity_reducer_top.sv
`timescale 1ns / 1ps
// top level of the learned clause activity reducer
// depends on lcar_pkg, lcar_req_if, lcar_rsp_if, lcar_csr, lcar_record_mem,
// lcar_engine and assert_macros.svh
//
// usage
//   req_if carries one beat per operation: load, bump, decay all, reduce or
//   read. every accepted beat gives exactly one beat on rsp_if, in order.
//   csr_* is an apb-style port: records in use at byte 0, decay factor at
//   byte 4. write it only while no operation is in flight.
// walks
//   decay all and reduce walk the n records in use. reduce walks them once
//   to count live learned records, then again to mark, and skips the second
//   walk when fewer than 200 are live. the single read port of the record
//   memory sets the pace of a walk: one record a cycle
// reset
//   reset is synchronous. afterwards the block sweeps all 1024 records of the
//   record memory, clearing the learned and removed flags; req_if.ready stays
//   low during the sweep, while register writes are taken as usual
// back pressure
//   the result sits in an output register; the next beat is taken while it
//   waits, and that beat's result holds in the engine until the register frees

`include "assert_macros.svh"

module learned_clause_activity_reducer_top (
   input  logic                            clock,
   input  logic                            reset,
   lcar_req_if.sink                        req_if,
   lcar_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lcar_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lcar_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lcar_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   lcar_pkg::cfg_type     cfg;
   lcar_pkg::req_type     req_data;
   lcar_pkg::rsp_type     res_data;
   lcar_pkg::rsp_type     rsp_data_ff;
   lcar_pkg::mem_req_type mem_req;
   lcar_pkg::record_type  mem_rd_data;
   logic                  req_ready;
   logic                  res_push;
   logic                  res_free;
   logic                  rsp_valid_ff, rsp_valid_in;

   // register block
   lcar_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // gather the request beat into one word
   assign req_data.mode          = req_if.mode;
   assign req_data.index         = req_if.index;
   assign req_data.learned_in    = req_if.learned_in;
   assign req_data.removed_in    = req_if.removed_in;
   assign req_data.literal_count = req_if.literal_count;
   assign req_data.activity_in   = req_if.activity_in;
   assign req_if.ready           = req_ready;

   lcar_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_if.valid),
      .req_data    (req_data),
      .req_ready   (req_ready),
      .res_push    (res_push),
      .res_data    (res_data),
      .res_free    (res_free),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   // all record state lives here
   lcar_record_mem u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign res_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.index_out    = rsp_data_ff.index_out;
   assign rsp_if.learned_out  = rsp_data_ff.learned_out;
   assign rsp_if.removed_out  = rsp_data_ff.removed_out;
   assign rsp_if.activity_out = rsp_data_ff.activity_out;
   assign rsp_if.live_learned = rsp_data_ff.live_learned;
   assign rsp_if.removed_now  = rsp_data_ff.removed_now;
   assign rsp_if.reduce_ran   = rsp_data_ff.reduce_ran;

   // a walk never reads the entry it writes back in the same cycle
   `LCAR_ASSERT(a_no_rw_same_entry, clock, reset, (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr), "read and write hit the same record")
   // a result only lands in a free output register
   `LCAR_ASSERT(a_push_when_free, clock, reset, res_push |-> (!rsp_valid_ff || rsp_if.ready), "result pushed over a waiting beat")
   // no request is taken while the memory is being written
   `LCAR_ASSERT(a_no_accept_on_write, clock, reset, mem_req.wr_en |-> !req_ready, "request taken during a record write")
   // reset empties the output register
   `LCAR_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_if.valid, "response valid after reset")

endmodule

FILE: sv/lcar_csr.sv
`timescale 1ns / 1ps
// apb-style register block: records in use and decay factor
// depends on lcar_pkg

module lcar_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lcar_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lcar_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lcar_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output lcar_pkg::cfg_type               cfg
);

   logic [lcar_pkg::CFG_N_W-1:0]  entries_ff;
   logic [lcar_pkg::FACTOR_W-1:0] decay_ff;
   logic                          wr_en;
   lcar_pkg::csr_index_type       sel;

   // word address bit picks the register
   assign sel    = lcar_pkg::csr_index_type'(paddr[lcar_pkg::CSR_ADDR_W-1]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         decay_ff   <= lcar_pkg::DECAY_RESET;
      end else if (wr_en) begin
         unique case (sel)
            lcar_pkg::CSR_ENTRIES_IN_USE: entries_ff <= pwdata[lcar_pkg::CFG_N_W-1:0];
            lcar_pkg::CSR_DECAY_FACTOR:   decay_ff   <= pwdata[lcar_pkg::FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         lcar_pkg::CSR_ENTRIES_IN_USE: prdata = lcar_pkg::CSR_DATA_W'(entries_ff);
         lcar_pkg::CSR_DECAY_FACTOR:   prdata = lcar_pkg::CSR_DATA_W'(decay_ff);
         default:                      prdata = '0;
      endcase
   end

   assign cfg.entries_in_use = entries_ff;
   assign cfg.decay_factor   = decay_ff;

endmodule

FILE: sv/lcar_record_mem.sv
`timescale 1ns / 1ps
// clause record store: one write port, one registered read port
// depends on lcar_pkg

module lcar_record_mem (
   input  logic                  clock,
   input  lcar_pkg::mem_req_type req,
   output lcar_pkg::record_type  rd_data
);

   lcar_pkg::record_type records_ff [lcar_pkg::ENTRIES];
   lcar_pkg::record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         records_ff[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= records_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lcar_decay_mul.sv
`timescale 1ns / 1ps
// activity times q1.16 factor, two registered partial products then one add
// depends on lcar_pkg

module lcar_decay_mul (
   input  logic                          clock,
   input  logic [lcar_pkg::ACT_W-1:0]    activity,
   input  logic [lcar_pkg::FACTOR_W-1:0] factor,
   output logic [lcar_pkg::ACT_W-1:0]    product
);

   logic [lcar_pkg::PROD_W-1:0] hi_prod_ff, hi_prod_in;
   logic [lcar_pkg::PROD_W-1:0] lo_prod_ff, lo_prod_in;
   logic [lcar_pkg::SUM_W-1:0]  sum;

   assign hi_prod_in = lcar_pkg::PROD_W'(activity[lcar_pkg::ACT_W-1:lcar_pkg::HALF_W])
                     * lcar_pkg::PROD_W'(factor);
   assign lo_prod_in = lcar_pkg::PROD_W'(activity[lcar_pkg::HALF_W-1:0])
                     * lcar_pkg::PROD_W'(factor);

   always_ff @(posedge clock) begin
      hi_prod_ff <= hi_prod_in;
      lo_prod_ff <= lo_prod_in;
   end

   assign sum = {hi_prod_ff, lcar_pkg::HALF_W'(0)}
              + lcar_pkg::SUM_W'(lo_prod_ff);

   // drop the fraction bits of the factor, truncating
   assign product = sum[lcar_pkg::FRAC_W +: lcar_pkg::ACT_W];

endmodule

FILE: sv/lcar_engine.sv
`timescale 1ns / 1ps
// sequencer for the record operations: single-record access and table walks
// depends on lcar_pkg and lcar_decay_mul

module lcar_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  lcar_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   input  lcar_pkg::req_type     req_data,
   output logic                  req_ready,
   output logic                  res_push,
   output lcar_pkg::rsp_type     res_data,
   input  logic                  res_free,
   output lcar_pkg::mem_req_type mem_req,
   input  lcar_pkg::record_type  mem_rd_data
);

   lcar_pkg::state_type          state_ff, state_in;
   lcar_pkg::req_type            item_ff, item_in;
   lcar_pkg::rsp_type            res_ff, res_in;
   logic [lcar_pkg::COUNT_W-1:0] addr_ff, addr_in;
   logic                         p1_valid_ff, p1_valid_in;
   logic [lcar_pkg::INDEX_W-1:0] p1_addr_ff, p1_addr_in;
   logic                         p2_valid_ff, p2_valid_in;
   logic [lcar_pkg::INDEX_W-1:0] p2_addr_ff;
   lcar_pkg::record_type         p2_rec_ff;
   logic [lcar_pkg::COUNT_W-1:0] live_ff, live_in;
   logic [lcar_pkg::MARK_W-1:0]  marked_ff, marked_in;
   logic [lcar_pkg::MARK_W-1:0]  budget_ff, budget_in;

   logic [lcar_pkg::COUNT_W-1:0]      used_n;
   logic [lcar_pkg::FACTOR_W-1:0]     factor;
   logic [lcar_pkg::ACT_W-1:0]        decayed;
   logic [lcar_pkg::ACT_W:0]          bump_sum;
   logic [lcar_pkg::ACT_W-1:0]        bumped;
   logic [lcar_pkg::THIRD_PROD_W-1:0] third_prod;
   logic                              walking;
   logic                              walk_done;
   logic                              rec_live;
   logic                              mark_hit;
   logic                              min_met;
   logic                              single_mode;

   // records in use and decay factor, both saturated
   assign used_n = (cfg.entries_in_use > lcar_pkg::COUNT_W'(lcar_pkg::ENTRIES))
                 ? lcar_pkg::COUNT_W'(lcar_pkg::ENTRIES) : cfg.entries_in_use;
   assign factor = (cfg.decay_factor > lcar_pkg::FACTOR_ONE)
                 ? lcar_pkg::FACTOR_ONE : cfg.decay_factor;

   lcar_decay_mul u_mul (
      .clock    (clock),
      .activity (mem_rd_data.activity),
      .factor   (factor),
      .product  (decayed)
   );

   assign bump_sum = {1'b0, mem_rd_data.activity} + {1'b0, lcar_pkg::ONE_Q16};
   assign bumped   = bump_sum[lcar_pkg::ACT_W] ? lcar_pkg::ACT_MAX
                   : bump_sum[lcar_pkg::ACT_W-1:0];

   assign third_prod = lcar_pkg::THIRD_PROD_W'(live_ff)
                     * lcar_pkg::THIRD_PROD_W'(lcar_pkg::THIRD_RECIP);
   assign min_met    = 32'(live_ff) >= 32'(lcar_pkg::REDUCE_MINIMUM);

   assign walking   = (state_ff == lcar_pkg::ST_DECAY) || (state_ff == lcar_pkg::ST_COUNT)
                   || (state_ff == lcar_pkg::ST_MARK);
   assign walk_done = (addr_ff == used_n) && !p1_valid_ff && !p2_valid_ff;

   assign rec_live = mem_rd_data.learned && !mem_rd_data.removed;
   assign mark_hit = p1_valid_ff && rec_live
                  && (mem_rd_data.literal_count > lcar_pkg::LIT_KEEP)
                  && (mem_rd_data.activity <= lcar_pkg::TWO_Q16)
                  && (marked_ff < budget_ff);

   assign single_mode = (req_data.mode == lcar_pkg::MODE_LOAD)
                     || (req_data.mode == lcar_pkg::MODE_BUMP)
                     || (req_data.mode == lcar_pkg::MODE_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcar_pkg::ST_CLEAR: begin
            if (addr_ff == lcar_pkg::COUNT_W'(lcar_pkg::ENTRIES - 1)) begin
               state_in = lcar_pkg::ST_IDLE;
            end
         end
         lcar_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode) inside
                  lcar_pkg::MODE_LOAD:                      state_in = lcar_pkg::ST_LOAD;
                  lcar_pkg::MODE_BUMP, lcar_pkg::MODE_READ: state_in = lcar_pkg::ST_SINGLE_RD;
                  lcar_pkg::MODE_DECAY:                     state_in = lcar_pkg::ST_DECAY;
                  lcar_pkg::MODE_REDUCE:                    state_in = lcar_pkg::ST_COUNT;
                  default:                                  state_in = lcar_pkg::ST_FINISH;
               endcase
            end
         end
         lcar_pkg::ST_LOAD:      state_in = lcar_pkg::ST_FINISH;
         lcar_pkg::ST_SINGLE_RD: state_in = lcar_pkg::ST_SINGLE_WB;
         lcar_pkg::ST_SINGLE_WB: state_in = lcar_pkg::ST_FINISH;
         lcar_pkg::ST_DECAY: begin
            if (walk_done) begin
               state_in = lcar_pkg::ST_FINISH;
            end
         end
         lcar_pkg::ST_COUNT: begin
            if (walk_done) begin
               state_in = lcar_pkg::ST_BUDGET;
            end
         end
         lcar_pkg::ST_BUDGET: begin
            state_in = min_met ? lcar_pkg::ST_MARK : lcar_pkg::ST_FINISH;
         end
         lcar_pkg::ST_MARK: begin
            if (walk_done) begin
               state_in = lcar_pkg::ST_FINISH;
            end
         end
         lcar_pkg::ST_FINISH: begin
            if (res_free) begin
               state_in = lcar_pkg::ST_IDLE;
            end
         end
         default: state_in = lcar_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_req     = '0;
      req_ready   = 1'b0;
      res_push    = 1'b0;
      item_in     = item_ff;
      res_in      = res_ff;
      addr_in     = addr_ff;
      live_in     = live_ff;
      marked_in   = marked_ff;
      budget_in   = budget_ff;
      p1_valid_in = 1'b0;
      p1_addr_in  = addr_ff[lcar_pkg::INDEX_W-1:0];
      p2_valid_in = p1_valid_ff && (state_ff == lcar_pkg::ST_DECAY);

      // walk read issue, one record a cycle
      if (walking && (addr_ff < used_n)) begin
         mem_req.rd_en   = 1'b1;
         mem_req.rd_addr = addr_ff[lcar_pkg::INDEX_W-1:0];
         p1_valid_in     = 1'b1;
         addr_in         = addr_ff + 1'b1;
      end

      unique case (state_ff)
         lcar_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_ff[lcar_pkg::INDEX_W-1:0];
            mem_req.wr_data = '0;
            addr_in         = addr_ff + 1'b1;
         end
         lcar_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in   = req_data;
               addr_in   = '0;
               live_in   = '0;
               marked_in = '0;
               res_in    = '0;
               if (single_mode) begin
                  res_in.index_out = req_data.index;
               end
            end
         end
         lcar_pkg::ST_LOAD: begin
            mem_req.wr_en                 = 1'b1;
            mem_req.wr_addr               = item_ff.index;
            mem_req.wr_data.learned       = item_ff.learned_in;
            mem_req.wr_data.removed       = item_ff.removed_in;
            mem_req.wr_data.literal_count = item_ff.literal_count;
            mem_req.wr_data.activity      = item_ff.activity_in;
            res_in.learned_out            = item_ff.learned_in;
            res_in.removed_out            = item_ff.removed_in;
            res_in.activity_out           = item_ff.activity_in;
         end
         lcar_pkg::ST_SINGLE_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = item_ff.index;
         end
         lcar_pkg::ST_SINGLE_WB: begin
            res_in.learned_out  = mem_rd_data.learned;
            res_in.removed_out  = mem_rd_data.removed;
            res_in.activity_out = mem_rd_data.activity;
            if (item_ff.mode == lcar_pkg::MODE_BUMP) begin
               mem_req.wr_en            = 1'b1;
               mem_req.wr_addr          = item_ff.index;
               mem_req.wr_data          = mem_rd_data;
               mem_req.wr_data.activity = bumped;
               res_in.activity_out      = bumped;
            end
         end
         lcar_pkg::ST_DECAY: begin
            if (p2_valid_ff) begin
               mem_req.wr_en            = 1'b1;
               mem_req.wr_addr          = p2_addr_ff;
               mem_req.wr_data          = p2_rec_ff;
               mem_req.wr_data.activity = decayed;
            end
         end
         lcar_pkg::ST_COUNT: begin
            if (p1_valid_ff && rec_live) begin
               live_in = live_ff + 1'b1;
            end
         end
         lcar_pkg::ST_BUDGET: begin
            addr_in             = '0;
            budget_in           = third_prod[lcar_pkg::THIRD_SHIFT +: lcar_pkg::MARK_W];
            res_in.live_learned = live_ff;
            res_in.reduce_ran   = min_met;
         end
         lcar_pkg::ST_MARK: begin
            if (mark_hit) begin
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = p1_addr_ff;
               mem_req.wr_data         = mem_rd_data;
               mem_req.wr_data.removed = 1'b1;
               marked_in               = marked_ff + 1'b1;
            end
            res_in.removed_now = marked_in;
         end
         lcar_pkg::ST_FINISH: begin
            res_push = res_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lcar_pkg::ST_CLEAR;
         addr_ff     <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      res_ff     <= res_in;
      live_ff    <= live_in;
      marked_ff  <= marked_in;
      budget_ff  <= budget_in;
      p1_addr_ff <= p1_addr_in;
      p2_addr_ff <= p1_addr_ff;
      p2_rec_ff  <= mem_rd_data;
   end

   assign res_data = res_ff;

endmodule
